// ===== src/qtue_pkg.sv =====
// Shared types and constants of the Q-table update engine.
// Holds the item structs, command and status codes, controller states and the
// command and status structs between controller and datapath. No dependencies.
package qtue_pkg;

    // Width of an action index inside the engine; covers up to eight actions.
    localparam int IDX_W = 3;

    // Command codes of an input item.
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // Register indexes, taken from the word address of the APB port.
    localparam logic REG_LEARNING_RATE = 1'b0;
    localparam logic REG_DISCOUNT      = 1'b1;

    // Reset values of the registers, unsigned Q0.16.
    localparam logic [15:0] LEARNING_RATE_RST = 16'd6554;
    localparam logic [15:0] DISCOUNT_RST      = 16'd58982;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         current_state;
        logic [1:0]         action_taken;
        logic [7:0]         next_state;
        logic signed [31:0] value_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] new_q;
        logic [1:0]         best_action;
        logic signed [31:0] best_q;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DRAIN,
        S_READQ,
        S_BOOT,
        S_TARGET,
        S_PROD,
        S_ROUND,
        S_FINISH
    } t_state;

    // Which kind of result the datapath formats when it loads the output.
    typedef enum logic [1:0] {
        RES_RANGE,
        RES_LOAD,
        RES_UPDATE,
        RES_QUERY
    } t_res_kind;

    typedef struct packed {
        logic             capture;
        logic             rd_en;
        logic             rd_next;
        logic             rd_scan;
        logic [IDX_W-1:0] rd_idx;
        logic             boot;
        logic             target;
        logic             prod;
        logic             round_en;
        logic             out_load;
        t_res_kind        res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic       bad;
        logic       out_busy;
    } t_dp_status;

endpackage

// ===== src/qtue_ctrl.sv =====
// Controller of the Q-table update engine: one state machine that sequences
// the row scan, the update arithmetic and the result hand-off.
// Depends on qtue_pkg.
module qtue_ctrl #(
    parameter int NUM_ACTIONS = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  qtue_pkg::t_dp_status i_status,
    output qtue_pkg::t_dp_cmd   o_cmd
);

    localparam logic [qtue_pkg::IDX_W-1:0] LAST_IDX = qtue_pkg::IDX_W'(NUM_ACTIONS - 1);

    qtue_pkg::t_state              r_state, n_state;
    logic [qtue_pkg::IDX_W-1:0]    r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qtue_pkg::S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_k            = r_k;
        o_cmd          = '0;
        o_cmd.res_kind = qtue_pkg::RES_RANGE;
        o_in_stall     = (r_state != qtue_pkg::S_IDLE);
        unique case (r_state)
            qtue_pkg::S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = qtue_pkg::S_DECODE;
                end
            end
            qtue_pkg::S_DECODE: begin
                n_k = '0;
                if (i_status.bad || i_status.command == qtue_pkg::CMD_LOAD) begin
                    n_state = qtue_pkg::S_FINISH;
                end else begin
                    n_state = qtue_pkg::S_SCAN;
                end
            end
            qtue_pkg::S_SCAN: begin
                // An update scans the successor row, a query its own row.
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_scan = 1'b1;
                o_cmd.rd_next = (i_status.command == qtue_pkg::CMD_UPDATE);
                o_cmd.rd_idx  = r_k;
                n_k           = r_k + 1'b1;
                if (r_k == LAST_IDX) begin
                    if (i_status.command == qtue_pkg::CMD_UPDATE) begin
                        n_state = qtue_pkg::S_READQ;
                    end else begin
                        n_state = qtue_pkg::S_DRAIN;
                    end
                end
            end
            qtue_pkg::S_DRAIN: begin
                n_state = qtue_pkg::S_FINISH;
            end
            qtue_pkg::S_READQ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = qtue_pkg::S_BOOT;
            end
            qtue_pkg::S_BOOT: begin
                o_cmd.boot = 1'b1;
                n_state    = qtue_pkg::S_TARGET;
            end
            qtue_pkg::S_TARGET: begin
                o_cmd.target = 1'b1;
                n_state      = qtue_pkg::S_PROD;
            end
            qtue_pkg::S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = qtue_pkg::S_ROUND;
            end
            qtue_pkg::S_ROUND: begin
                o_cmd.round_en = 1'b1;
                n_state        = qtue_pkg::S_FINISH;
            end
            qtue_pkg::S_FINISH: begin
                if (i_status.bad) begin
                    o_cmd.res_kind = qtue_pkg::RES_RANGE;
                end else if (i_status.command == qtue_pkg::CMD_LOAD) begin
                    o_cmd.res_kind = qtue_pkg::RES_LOAD;
                end else if (i_status.command == qtue_pkg::CMD_UPDATE) begin
                    o_cmd.res_kind = qtue_pkg::RES_UPDATE;
                end else begin
                    o_cmd.res_kind = qtue_pkg::RES_QUERY;
                end
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = qtue_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = qtue_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/qtue_datapath.sv =====
// Datapath of the Q-table update engine: the Q table memory, the row maximum,
// the fixed-point update chain and the output register.
// Depends on qtue_pkg; driven by qtue_ctrl through t_dp_cmd.
module qtue_datapath #(
    parameter int NUM_STATES  = 144,
    parameter int NUM_ACTIONS = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qtue_pkg::t_in_item   i_item,
    input  logic [15:0]          i_learning_rate,
    input  logic [15:0]          i_discount,
    input  qtue_pkg::t_dp_cmd    i_cmd,
    output qtue_pkg::t_dp_status o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output qtue_pkg::t_out_item  o_out_item
);

    localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [31:0] mem [DEPTH];

    qtue_pkg::t_in_item         r_item;
    logic                       r_bad, n_bad;
    logic [ADDR_W-1:0]          r_cur_base;
    logic [ADDR_W-1:0]          r_next_base;
    logic [ADDR_W-1:0]          w_rd_addr;
    logic [ADDR_W-1:0]          w_wr_addr;
    logic [31:0]                r_mem_q;
    logic                       r_rd_vld;
    logic                       r_rd_scan;
    logic [qtue_pkg::IDX_W-1:0] r_rd_idx;
    logic signed [31:0]         r_max;
    logic [qtue_pkg::IDX_W-1:0] r_arg;
    logic signed [31:0]         r_q;
    logic signed [48:0]         r_boot_prod;
    logic signed [48:0]         w_boot_sum;
    logic signed [32:0]         w_boot;
    logic signed [33:0]         r_target;
    logic [16:0]                w_one_minus_alpha;
    logic signed [49:0]         r_p1;
    logic signed [50:0]         r_p2;
    logic signed [51:0]         w_acc;
    logic signed [35:0]         w_rnd;
    logic                       w_sat;
    logic signed [31:0]         r_res;
    logic                       r_sat;
    logic                       r_out_valid;
    qtue_pkg::t_out_item        r_out, n_out;
    logic                       w_wr_en;

    // Range check of the arriving item.
    always_comb begin
        case (i_item.command)
            qtue_pkg::CMD_LOAD: begin
                n_bad = (int'(i_item.current_state) >= NUM_STATES)
                     || (int'(i_item.action_taken) >= NUM_ACTIONS);
            end
            qtue_pkg::CMD_UPDATE: begin
                n_bad = (int'(i_item.current_state) >= NUM_STATES)
                     || (int'(i_item.action_taken) >= NUM_ACTIONS)
                     || (int'(i_item.next_state) >= NUM_STATES);
            end
            qtue_pkg::CMD_QUERY: begin
                n_bad = (int'(i_item.current_state) >= NUM_STATES);
            end
            default: begin
                n_bad = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item      <= i_item;
            r_bad       <= n_bad;
            r_cur_base  <= ADDR_W'(i_item.current_state) * ADDR_W'(NUM_ACTIONS);
            r_next_base <= ADDR_W'(i_item.next_state) * ADDR_W'(NUM_ACTIONS);
        end
    end

    assign o_status.command  = r_item.command;
    assign o_status.bad      = r_bad;
    assign o_status.out_busy = r_out_valid && i_out_stall;

    // Table memory: one read and one write port, registered read data.
    always_comb begin
        if (i_cmd.rd_scan) begin
            w_rd_addr = (i_cmd.rd_next ? r_next_base : r_cur_base) + ADDR_W'(i_cmd.rd_idx);
        end else begin
            w_rd_addr = r_cur_base + ADDR_W'(r_item.action_taken);
        end
    end

    assign w_wr_addr = r_cur_base + ADDR_W'(r_item.action_taken);
    assign w_wr_en   = i_cmd.out_load
                    && (i_cmd.res_kind == qtue_pkg::RES_LOAD
                     || i_cmd.res_kind == qtue_pkg::RES_UPDATE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_mem_q <= mem[w_rd_addr];
        end
        if (w_wr_en) begin
            mem[w_wr_addr] <= (i_cmd.res_kind == qtue_pkg::RES_LOAD) ? r_item.value_in : r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_scan <= i_cmd.rd_scan;
        r_rd_idx  <= i_cmd.rd_idx;
    end

    // Running maximum of the scanned row; a later entry must be strictly greater.
    always_ff @(posedge i_clk) begin
        if (r_rd_vld && r_rd_scan) begin
            if (r_rd_idx == '0 || $signed(r_mem_q) > r_max) begin
                r_max <= $signed(r_mem_q);
                r_arg <= r_rd_idx;
            end
        end
        if (r_rd_vld && !r_rd_scan) begin
            r_q <= $signed(r_mem_q);
        end
    end

    // Update chain: gamma * max, round and add reward, two products, round and clamp.
    assign w_boot_sum        = r_boot_prod + 49'sd32768;
    assign w_boot            = w_boot_sum[48:16];
    assign w_one_minus_alpha = 17'h1_0000 - {1'b0, i_learning_rate};
    assign w_acc             = 52'(r_p1) + 52'(r_p2) + 52'sd32768;
    assign w_rnd             = w_acc[51:16];
    assign w_sat             = !((&w_rnd[35:31]) || !(|w_rnd[35:31]));

    always_ff @(posedge i_clk) begin
        if (i_cmd.boot) begin
            r_boot_prod <= $signed({1'b0, i_discount}) * r_max;
        end
        if (i_cmd.target) begin
            r_target <= 34'(r_item.value_in) + 34'(w_boot);
        end
        if (i_cmd.prod) begin
            r_p1 <= $signed({1'b0, w_one_minus_alpha}) * r_q;
            r_p2 <= $signed({1'b0, i_learning_rate}) * r_target;
        end
        if (i_cmd.round_en) begin
            r_sat <= w_sat;
            if (w_sat) begin
                r_res <= w_rnd[35] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end else begin
                r_res <= w_rnd[31:0];
            end
        end
    end

    // Result formatting.
    always_comb begin
        n_out = '0;
        unique case (i_cmd.res_kind)
            qtue_pkg::RES_RANGE: begin
                n_out.status = qtue_pkg::ST_RANGE;
            end
            qtue_pkg::RES_LOAD: begin
                n_out.new_q  = r_item.value_in;
                n_out.status = qtue_pkg::ST_OK;
            end
            qtue_pkg::RES_UPDATE: begin
                n_out.new_q  = r_res;
                n_out.best_q = r_max;
                n_out.status = r_sat ? qtue_pkg::ST_SAT : qtue_pkg::ST_OK;
            end
            qtue_pkg::RES_QUERY: begin
                n_out.best_action = 2'(r_arg);
                n_out.best_q      = r_max;
                n_out.status      = qtue_pkg::ST_OK;
            end
            default: begin
                n_out.status = qtue_pkg::ST_RANGE;
            end
        endcase
    end

    // Output register: holds a finished item until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== src/q_table_update_engine.sv =====
// Top level of the Q-table update engine: APB configuration registers,
// controller and datapath. Depends on qtue_pkg, qtue_ctrl and qtue_datapath.
//
// The engine keeps a NUM_STATES by NUM_ACTIONS table of signed Q16.16 action
// values and handles one item at a time. A load item writes one entry, an
// update item applies the Q-learning rule with the learning rate and discount
// registers (unsigned Q0.16) and saturates the written value to 32 bits, and a
// query item returns the first maximum of a state's row. Every item gives one
// result item. A load or a rejected item skips the row scan; a query scans its
// own row, and an update scans the successor row and then runs the registered
// multiply chain. The row scan reads one entry per cycle through the single
// read port of the table memory. A finished result sits in an output register,
// so the next item is taken while the consumer still stalls. The table has no
// reset: each entry must be loaded before an update or query reads it, and
// there is no clearing pass after reset. Configuration must be written over
// APB at byte address 0 (learning rate) and 4 (discount), only while the
// engine is idle; the block itself does not enforce this. Reads return the
// register values.
module q_table_update_engine #(
    parameter int NUM_STATES  = 144,
    parameter int NUM_ACTIONS = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  qtue_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output qtue_pkg::t_out_item o_out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [15:0]          r_learning_rate;
    logic [15:0]          r_discount;
    logic                 w_cfg_write;
    qtue_pkg::t_dp_cmd    dp_cmd;
    qtue_pkg::t_dp_status dp_status;

    // The register file always answers in the access cycle.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_learning_rate <= qtue_pkg::LEARNING_RATE_RST;
            r_discount      <= qtue_pkg::DISCOUNT_RST;
        end else if (w_cfg_write) begin
            unique case (paddr[2])
                qtue_pkg::REG_LEARNING_RATE: r_learning_rate <= pwdata[15:0];
                qtue_pkg::REG_DISCOUNT:      r_discount      <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            qtue_pkg::REG_LEARNING_RATE: prdata = {16'd0, r_learning_rate};
            qtue_pkg::REG_DISCOUNT:      prdata = {16'd0, r_discount};
            default:                     prdata = '0;
        endcase
    end

    // The controller sequences each item; the datapath holds the table and math.
    qtue_ctrl #(
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    qtue_datapath #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_in_item),
        .i_learning_rate (r_learning_rate),
        .i_discount      (r_discount),
        .i_cmd           (dp_cmd),
        .o_status        (dp_status),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_item      (o_out_item)
    );

    // A result is never loaded over one that is still stalled at the output.
    a_no_result_overwrite: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> !dp_status.out_busy
    ) else $error("result loaded into a full output register");

    // Once an item is taken, the engine stalls the input until it is done.
    a_one_item_in_flight: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("input accepted on consecutive cycles");

    // The row scan never reads past the last action of a row.
    a_scan_in_row: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (dp_cmd.rd_en && dp_cmd.rd_scan) |-> (int'(dp_cmd.rd_idx) < NUM_ACTIONS)
    ) else $error("row scan index beyond the action count");

    // A captured item always yields a result loaded later, never in the same cycle.
    a_capture_not_load: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.capture |-> !dp_cmd.out_load
    ) else $error("capture and result load in the same cycle");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of q_table_update_engine: directed table, then random items.
// Uses qtue_pkg for item types, codes and reset values; needs only the RTL.
module testbench;

    localparam int NUM_STATES       = 144;
    localparam int NUM_ACTIONS      = 3;
    localparam int TABLE_DEPTH      = NUM_STATES * NUM_ACTIONS;
    localparam int DIRECTED_ROWS    = 25;
    localparam int NUM_PHASES       = 6;
    localparam int RANDOM_PER_PHASE = 290;
    localparam int IDLE_SETTLE      = 16;
    localparam int LIMIT_CYCLES     = 1_000_000;
    localparam int PRESSURE_AT      = 150;
    localparam int PRESSURE_CYCLES  = 400;
    localparam int REPORT_LIMIT     = 10;

    // The package names no code for the spare command value or the spare column.
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam logic [1:0] BAD_ACTION  = 2'd3;

    localparam logic [31:0] MAX_Q  = 32'h7fff_ffff;
    localparam logic [31:0] MIN_Q  = 32'h8000_0000;
    localparam logic [31:0] ONE_Q  = 32'h0001_0000;
    localparam logic [31:0] NEG_Q  = 32'hffff_ffff;
    localparam logic [31:0] ZERO_Q = 32'h0000_0000;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    // Clock, reset and every block input start at known values.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    qtue_pkg::t_in_item    i_in_item   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [2:0]            paddr       = '0;
    logic [31:0]           pwdata      = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    qtue_pkg::t_out_item   o_out_item;
    logic [31:0]           prdata;
    logic                  pready;

    always #1 i_clk = ~i_clk;

    q_table_update_engine #(
        .NUM_STATES (NUM_STATES),
        .NUM_ACTIONS(NUM_ACTIONS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Shadow copy of the action-value table and of the two rate registers.
    logic signed [31:0] q_shadow [TABLE_DEPTH];
    bit                 entry_loaded [TABLE_DEPTH];
    int                 alpha_reg = qtue_pkg::LEARNING_RATE_RST;
    int                 gamma_reg = qtue_pkg::DISCOUNT_RST;

    qtue_pkg::t_out_item expected_results [$];

    int mismatches   = 0;
    int results_seen = 0;
    int items_sent   = 0;
    int update_count = 0;
    int query_count  = 0;
    int reject_count = 0;
    int sat_count    = 0;
    bit pressure_done = 1'b0;

    // One directed row: the item, and the result where it is obvious by eye.
    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  state;
        logic [1:0]  action;
        logic [7:0]  next_st;
        logic [31:0] value;
        bit          typed;
        logic [31:0] new_q;
        logic [1:0]  best_action;
        logic [31:0] best_q;
        logic [1:0]  status;
    } t_stim_row;

    t_stim_row stim_table [DIRECTED_ROWS] = '{
        // Extreme values loaded into row 0, and a tie then a negative entry in the last row.
        '{qtue_pkg::CMD_LOAD,   8'd0,   2'd0, 8'd0,   MAX_Q,
          1'b1, MAX_Q,  2'd0, ZERO_Q, qtue_pkg::ST_OK},
        '{qtue_pkg::CMD_LOAD,   8'd0,   2'd1, 8'd0,   MIN_Q,
          1'b1, MIN_Q,  2'd0, ZERO_Q, qtue_pkg::ST_OK},
        '{qtue_pkg::CMD_LOAD,   8'd0,   2'd2, 8'd0,   ZERO_Q,
          1'b1, ZERO_Q, 2'd0, ZERO_Q, qtue_pkg::ST_OK},
        '{qtue_pkg::CMD_LOAD,   8'd143, 2'd0, 8'd0,   ONE_Q,
          1'b1, ONE_Q,  2'd0, ZERO_Q, qtue_pkg::ST_OK},
        '{qtue_pkg::CMD_LOAD,   8'd143, 2'd1, 8'd0,   ONE_Q,
          1'b1, ONE_Q,  2'd0, ZERO_Q, qtue_pkg::ST_OK},
        '{qtue_pkg::CMD_LOAD,   8'd143, 2'd2, 8'd0,   NEG_Q,
          1'b1, NEG_Q,  2'd0, ZERO_Q, qtue_pkg::ST_OK},
        // On a tie the lowest action wins.
        '{qtue_pkg::CMD_QUERY,  8'd143, 2'd0, 8'd0,   ZERO_Q,
          1'b1, ZERO_Q, 2'd0, ONE_Q,  qtue_pkg::ST_OK},
        '{qtue_pkg::CMD_QUERY,  8'd0,   2'd0, 8'd0,   ZERO_Q,
          1'b1, ZERO_Q, 2'd0, MAX_Q,  qtue_pkg::ST_OK},
        // Every index that can be out of range, and the unknown command.
        '{qtue_pkg::CMD_LOAD,   8'd255, 2'd0, 8'd0,   ONE_Q,
          1'b1, ZERO_Q, 2'd0, ZERO_Q, qtue_pkg::ST_RANGE},
        '{qtue_pkg::CMD_LOAD,   8'd144, 2'd0, 8'd0,   ONE_Q,
          1'b1, ZERO_Q, 2'd0, ZERO_Q, qtue_pkg::ST_RANGE},
        '{qtue_pkg::CMD_LOAD,   8'd5,   2'd3, 8'd0,   ONE_Q,
          1'b1, ZERO_Q, 2'd0, ZERO_Q, qtue_pkg::ST_RANGE},
        '{qtue_pkg::CMD_UPDATE, 8'd0,   2'd0, 8'd200, ONE_Q,
          1'b1, ZERO_Q, 2'd0, ZERO_Q, qtue_pkg::ST_RANGE},
        '{qtue_pkg::CMD_UPDATE, 8'd0,   2'd3, 8'd0,   ONE_Q,
          1'b1, ZERO_Q, 2'd0, ZERO_Q, qtue_pkg::ST_RANGE},
        '{qtue_pkg::CMD_UPDATE, 8'd144, 2'd0, 8'd0,   ONE_Q,
          1'b1, ZERO_Q, 2'd0, ZERO_Q, qtue_pkg::ST_RANGE},
        '{qtue_pkg::CMD_QUERY,  8'd144, 2'd0, 8'd0,   ZERO_Q,
          1'b1, ZERO_Q, 2'd0, ZERO_Q, qtue_pkg::ST_RANGE},
        '{CMD_UNKNOWN,          8'd7,   2'd1, 8'd9,   ONE_Q,
          1'b1, ZERO_Q, 2'd0, ZERO_Q, qtue_pkg::ST_RANGE},
        // Largest reward on the largest entry saturates high with the reset rates.
        '{qtue_pkg::CMD_UPDATE, 8'd0,   2'd0, 8'd0,   MAX_Q,
          1'b1, MAX_Q,  2'd0, MAX_Q,  qtue_pkg::ST_SAT},
        '{qtue_pkg::CMD_LOAD,   8'd1,   2'd0, 8'd0,   MIN_Q,
          1'b1, MIN_Q,  2'd0, ZERO_Q, qtue_pkg::ST_OK},
        '{qtue_pkg::CMD_LOAD,   8'd1,   2'd1, 8'd0,   MIN_Q,
          1'b1, MIN_Q,  2'd0, ZERO_Q, qtue_pkg::ST_OK},
        '{qtue_pkg::CMD_LOAD,   8'd1,   2'd2, 8'd0,   MIN_Q,
          1'b1, MIN_Q,  2'd0, ZERO_Q, qtue_pkg::ST_OK},
        // A row of minimum values with the most negative reward saturates low.
        '{qtue_pkg::CMD_UPDATE, 8'd1,   2'd0, 8'd1,   MIN_Q,
          1'b1, MIN_Q,  2'd0, MIN_Q,  qtue_pkg::ST_SAT},
        '{qtue_pkg::CMD_UPDATE, 8'd0,   2'd1, 8'd143, NEG_Q,
          1'b0, ZERO_Q, 2'd0, ZERO_Q, qtue_pkg::ST_OK},
        '{qtue_pkg::CMD_LOAD,   8'd143, 2'd2, 8'd0,   MAX_Q,
          1'b1, MAX_Q,  2'd0, ZERO_Q, qtue_pkg::ST_OK},
        // The maximum in the last column is found.
        '{qtue_pkg::CMD_QUERY,  8'd143, 2'd0, 8'd0,   ZERO_Q,
          1'b1, ZERO_Q, 2'd2, MAX_Q,  qtue_pkg::ST_OK},
        '{qtue_pkg::CMD_QUERY,  8'd1,   2'd0, 8'd0,   ZERO_Q,
          1'b1, ZERO_Q, 2'd0, MIN_Q,  qtue_pkg::ST_OK}
    };

    // Rates per phase; a negative entry means a random setting. Phase 0 keeps the reset values.
    int phase_alpha [NUM_PHASES] = '{6554, 0, 65535, 32768, -1, 1};
    int phase_gamma [NUM_PHASES] = '{58982, 0, 65535, 16384, -1, 65535};

    // floor(x / 2^16 + 1/2); the shift is arithmetic on a signed 64-bit value.
    function automatic longint round_half_up(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    // First maximum of a row of the shadow table.
    function automatic longint row_best(input int s, output logic [1:0] arg);
        longint best;
        int     a;
        best = q_shadow[s * NUM_ACTIONS];
        arg  = 2'd0;
        for (a = 1; a < NUM_ACTIONS; a++) begin
            if (q_shadow[s * NUM_ACTIONS + a] > best) begin
                best = q_shadow[s * NUM_ACTIONS + a];
                arg  = a[1:0];
            end
        end
        return best;
    endfunction

    // Applies one accepted item to the shadow table and returns the result it must give.
    function automatic qtue_pkg::t_out_item apply_command(input qtue_pkg::t_in_item it);
        qtue_pkg::t_out_item res;
        int                  idx;
        longint              peak;
        longint              old_q;
        longint              target;
        longint              acc;
        longint              rounded;
        logic [1:0]          arg;
        res = '0;
        res.status = qtue_pkg::ST_OK;
        idx = it.current_state * NUM_ACTIONS + it.action_taken;
        case (it.command)
            qtue_pkg::CMD_LOAD: begin
                if (it.current_state >= NUM_STATES || it.action_taken >= NUM_ACTIONS) begin
                    res.status = qtue_pkg::ST_RANGE;
                end else begin
                    q_shadow[idx]     = it.value_in;
                    entry_loaded[idx] = 1'b1;
                    res.new_q         = it.value_in;
                end
            end
            qtue_pkg::CMD_UPDATE: begin
                update_count++;
                if (it.current_state >= NUM_STATES || it.action_taken >= NUM_ACTIONS ||
                    it.next_state >= NUM_STATES) begin
                    res.status = qtue_pkg::ST_RANGE;
                end else begin
                    peak    = row_best(it.next_state, arg);
                    old_q   = q_shadow[idx];
                    target  = longint'($signed(it.value_in))
                            + round_half_up(longint'(gamma_reg) * peak);
                    acc     = longint'(65536 - alpha_reg) * old_q + longint'(alpha_reg) * target;
                    rounded = round_half_up(acc);
                    if (rounded > SAT_HI) begin
                        rounded    = SAT_HI;
                        res.status = qtue_pkg::ST_SAT;
                    end else if (rounded < SAT_LO) begin
                        rounded    = SAT_LO;
                        res.status = qtue_pkg::ST_SAT;
                    end
                    q_shadow[idx]     = rounded[31:0];
                    entry_loaded[idx] = 1'b1;
                    res.new_q         = rounded[31:0];
                    res.best_q        = peak[31:0];
                end
            end
            qtue_pkg::CMD_QUERY: begin
                query_count++;
                if (it.current_state >= NUM_STATES) begin
                    res.status = qtue_pkg::ST_RANGE;
                end else begin
                    peak            = row_best(it.current_state, arg);
                    res.best_action = arg;
                    res.best_q      = peak[31:0];
                end
            end
            default: begin
                res.status = qtue_pkg::ST_RANGE;
            end
        endcase
        if (res.status == qtue_pkg::ST_RANGE) reject_count++;
        if (res.status == qtue_pkg::ST_SAT) sat_count++;
        return res;
    endfunction

    function automatic bit row_loaded(input int s);
        int a;
        for (a = 0; a < NUM_ACTIONS; a++) begin
            if (!entry_loaded[s * NUM_ACTIONS + a]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Most traffic lands on a few low and a few high rows so that rows fill up early
    // and updates chain through each other's values.
    function automatic int pick_state();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return $urandom_range(0, 11);
        if (roll < 85) return $urandom_range(NUM_STATES - 16, NUM_STATES - 1);
        return $urandom_range(0, NUM_STATES - 1);
    endfunction

    function automatic logic [31:0] random_q();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return MAX_Q;
        if (roll == 1) return MIN_Q;
        if (roll < 5) return $urandom;
        // Values within plus or minus 16.0.
        return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endfunction

    // Random item that reads only entries already written. When no fitting entry
    // is found the item falls back to a load, which also fills the table.
    function automatic qtue_pkg::t_in_item make_random_item();
        qtue_pkg::t_in_item it;
        int                 roll;
        int                 tries;
        int                 s;
        int                 a;
        int                 ns;
        bit                 found;
        it.command       = qtue_pkg::CMD_LOAD;
        it.current_state = 8'(pick_state());
        it.action_taken  = 2'($urandom_range(0, NUM_ACTIONS - 1));
        it.next_state    = 8'($urandom_range(0, 255));
        it.value_in      = random_q();
        roll  = $urandom_range(0, 99);
        found = 1'b0;
        if (roll < 45 || roll >= 90) begin
            for (tries = 0; tries < 24 && !found; tries++) begin
                s     = pick_state();
                a     = $urandom_range(0, NUM_ACTIONS - 1);
                ns    = pick_state();
                found = entry_loaded[s * NUM_ACTIONS + a] && row_loaded(ns);
            end
            if (found) begin
                it.command       = qtue_pkg::CMD_UPDATE;
                it.current_state = 8'(s);
                it.action_taken  = 2'(a);
                it.next_state    = 8'(ns);
                // A broken update: one index pushed out of range.
                if (roll >= 90) begin
                    case ($urandom_range(0, 2))
                        0: it.current_state = 8'($urandom_range(NUM_STATES, 255));
                        1: it.action_taken  = BAD_ACTION;
                        default: it.next_state = 8'($urandom_range(NUM_STATES, 255));
                    endcase
                end
            end
        end else if (roll < 65) begin
            for (tries = 0; tries < 24 && !found; tries++) begin
                s     = pick_state();
                found = row_loaded(s);
            end
            if (found) begin
                it.command       = qtue_pkg::CMD_QUERY;
                it.current_state = 8'(s);
            end
        end else if (roll < 75) begin
            case ($urandom_range(0, 3))
                0: begin
                    it.command       = CMD_UNKNOWN;
                    it.current_state = 8'($urandom_range(0, 255));
                    it.action_taken  = 2'($urandom_range(0, 3));
                end
                1: it.current_state = 8'($urandom_range(NUM_STATES, 255));
                2: it.action_taken  = BAD_ACTION;
                default: begin
                    it.command       = qtue_pkg::CMD_QUERY;
                    it.current_state = 8'($urandom_range(NUM_STATES, 255));
                end
            endcase
        end
        return it;
    endfunction

    // Offers one item and returns at the clock edge that accepts it. Entered right
    // after a rising edge; valid stays high into the next item when no gap is drawn.
    task automatic send_item(input qtue_pkg::t_in_item it, input bit typed,
                             input qtue_pkg::t_out_item typed_res);
        int                  gap;
        int                  roll;
        qtue_pkg::t_out_item predicted;
        if ((items_sent % 250) < 50) begin
            gap = 0;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 40)      gap = 0;
            else if (roll < 85) gap = $urandom_range(1, 3);
            else if (roll < 97) gap = $urandom_range(4, 15);
            else                gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        predicted = apply_command(it);
        expected_results.push_back(typed ? typed_res : predicted);
    endtask

    // Stops offering items and lets the engine finish everything in flight.
    task automatic wait_until_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // One APB transfer: setup cycle, access cycle, then a return to idle.
    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_rates(input int alpha, input int gamma);
        logic [31:0] got_alpha;
        logic [31:0] got_gamma;
        apb_access(1'b0, {qtue_pkg::REG_LEARNING_RATE, 2'b00}, '0, got_alpha);
        apb_access(1'b0, {qtue_pkg::REG_DISCOUNT, 2'b00}, '0, got_gamma);
        if (got_alpha !== 32'(alpha) || got_gamma !== 32'(gamma)) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("testbench: rate readback expected %h/%h, got %h/%h",
                         32'(alpha), 32'(gamma), got_alpha, got_gamma);
        end
    endtask

    task automatic set_rates(input int alpha, input int gamma);
        logic [31:0] unused;
        apb_access(1'b1, {qtue_pkg::REG_LEARNING_RATE, 2'b00}, 32'(alpha), unused);
        apb_access(1'b1, {qtue_pkg::REG_DISCOUNT, 2'b00}, 32'(gamma), unused);
        alpha_reg = alpha;
        gamma_reg = gamma;
        check_rates(alpha, gamma);
    endtask

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        qtue_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"testbench: result with nothing expected: ",
                              "new_q=%h act=%0d best_q=%h st=%0d"},
                             o_out_item.new_q, o_out_item.best_action, o_out_item.best_q,
                             o_out_item.status);
            end else begin
                want = expected_results.pop_front();
                if (o_out_item.new_q !== want.new_q ||
                    o_out_item.best_action !== want.best_action ||
                    o_out_item.best_q !== want.best_q || o_out_item.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"testbench: result %0d expected new_q=%h act=%0d ",
                                  "best_q=%h st=%0d, got new_q=%h act=%0d best_q=%h st=%0d"},
                                 results_seen, want.new_q, want.best_action, want.best_q,
                                 want.status, o_out_item.new_q, o_out_item.best_action,
                                 o_out_item.best_q, o_out_item.status);
                end
            end
        end
    end

    // Receiver: stretches of free flow, random stalls and long stalls, plus one
    // long hold-off while items keep coming so that the engine fills up and
    // stalls its input.
    initial begin : result_stall
        int mode;
        int seg_len;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!pressure_done && results_seen >= PRESSURE_AT) begin
                i_out_stall <= 1'b1;
                repeat (PRESSURE_CYCLES) @(posedge i_clk);
                pressure_done = 1'b1;
            end else begin
                mode    = $urandom_range(0, 99);
                seg_len = $urandom_range(20, 80);
                repeat (seg_len) begin
                    if (mode < 25)      i_out_stall <= 1'b0;
                    else if (mode < 35) i_out_stall <= ($urandom_range(0, 99) < 90);
                    else                i_out_stall <= ($urandom_range(0, 99) < 30);
                    @(posedge i_clk);
                end
            end
        end
    end

    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("testbench: timed out after %0d cycles with %0d results pending",
                 LIMIT_CYCLES, expected_results.size());
        $display("testbench: FAIL");
        $finish;
    end

    initial begin : main_sequence
        qtue_pkg::t_in_item  stim;
        qtue_pkg::t_out_item typed_res;
        int                  row_idx;
        int                  phase;
        int                  n;
        int                  alpha;
        int                  gamma;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The registers come out of reset with their default rates.
        check_rates(qtue_pkg::LEARNING_RATE_RST, qtue_pkg::DISCOUNT_RST);

        for (row_idx = 0; row_idx < DIRECTED_ROWS; row_idx++) begin
            stim.command          = stim_table[row_idx].command;
            stim.current_state    = stim_table[row_idx].state;
            stim.action_taken     = stim_table[row_idx].action;
            stim.next_state       = stim_table[row_idx].next_st;
            stim.value_in         = stim_table[row_idx].value;
            typed_res.new_q       = stim_table[row_idx].new_q;
            typed_res.best_action = stim_table[row_idx].best_action;
            typed_res.best_q      = stim_table[row_idx].best_q;
            typed_res.status      = stim_table[row_idx].status;
            send_item(stim, stim_table[row_idx].typed, typed_res);
        end

        // Each phase runs under its own rates; registers change only when idle.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                wait_until_idle();
                alpha = (phase_alpha[phase] < 0) ? $urandom_range(0, 65535) : phase_alpha[phase];
                gamma = (phase_gamma[phase] < 0) ? $urandom_range(0, 65535) : phase_gamma[phase];
                set_rates(alpha, gamma);
            end
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                send_item(make_random_item(), 1'b0, '0);
            end
        end

        wait_until_idle();
        $display("testbench: %0d items sent over %0d rate settings: %0d updates, %0d queries",
                 items_sent, NUM_PHASES, update_count, query_count);
        $display("testbench: %0d results checked, %0d rejected, %0d saturated, %0d mismatches",
                 results_seen, reject_count, sat_count, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
